>>> rtl/sample_average_gamma_encoder_macros.svh
// Assertion helpers used by the checker file sage_checker.sv.
// Both expect clk and rst_n in the scope where they are used.
`ifndef SAMPLE_AVERAGE_GAMMA_ENCODER_MACROS_SVH
`define SAMPLE_AVERAGE_GAMMA_ENCODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SAGE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sage: same-cycle property violated");

// Consequent checked starting in the cycle after the antecedent.
`define SAGE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sage: next-cycle property violated");

`endif

>>> rtl/sage_pkg.sv
package sage_pkg;

    localparam int FRACTION_BITS_DEF    = 16;
    localparam int GAMMA_TABLE_BITS_DEF = 12;
    localparam int MAX_COLUMNS          = 4096;

    localparam int ACCUM_W     = 32;
    localparam int COUNT_W     = 16;
    localparam int COLUMN_W    = 12;
    localparam int CODE_W      = 8;
    localparam int CODE_LEVELS = 256;
    localparam int CODE_MAX    = 255;
    localparam int CHANNELS    = 3;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Threshold entry width: holds 2^GAMMA_TABLE_BITS for the largest table size.
    localparam int GTW = 17;

    // Stages outside the divider and the code search: input, overflow check, output.
    localparam int FIXED_STAGES = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MARKER_COLUMN = CFG_INDEX_W'(1);

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NORMAL = 2'd0;
    localparam kind_t KIND_BLANK  = 2'd1;
    localparam kind_t KIND_MARKER = 2'd2;

    typedef struct packed {
        logic                valid;
        kind_t               kind;
        logic [CHANNELS-1:0] ovf;
    } ctl_t;

    typedef struct packed {
        logic [ACCUM_W-1:0]  accum_red;
        logic [ACCUM_W-1:0]  accum_green;
        logic [ACCUM_W-1:0]  accum_blue;
        logic [COLUMN_W-1:0] pixel_column;
    } pixel_t;

    typedef struct packed {
        logic [CODE_W-1:0] red;
        logic [CODE_W-1:0] green;
        logic [CODE_W-1:0] blue;
    } result_t;

    function automatic int quotient_bits(input int f, input int g);
        return (g <= f) ? g : f;
    endfunction

    function automatic int divisor_shift(input int f, input int g);
        return (f >= g) ? f - g : 0;
    endfunction

    function automatic int compare_width(input int f);
        return (COUNT_W + f > ACCUM_W) ? COUNT_W + f : ACCUM_W;
    endfunction

    function automatic int pipe_latency(input int f, input int g);
        return quotient_bits(f, g) + CODE_W + FIXED_STAGES;
    endfunction

    // Entry c: smallest table index i with i^5 * 510^11 >= (2c-1)^11 * 2^(5g),
    // i.e. the first index whose rounded encoding reaches code c.
    function automatic logic [GTW*CODE_LEVELS-1:0] gamma_thresholds(input int g);
        logic [GTW*CODE_LEVELS-1:0] tbl;
        logic [255:0]               base;
        logic [255:0]               lim;
        logic [255:0]               lhs;
        int                         lo;
        int                         hi;
        int                         mid;
        tbl  = '0;
        base = 256'd1;
        for (int k = 0; k < 11; k++) begin
            base = base * 256'd510;
        end
        for (int c = 1; c < CODE_LEVELS; c++) begin
            lim = 256'd1;
            for (int k = 0; k < 11; k++) begin
                lim = lim * 256'(2 * c - 1);
            end
            lim = lim << (5 * g);
            lo  = 0;
            hi  = 1 << g;
            for (int s = 0; s < GTW + 1; s++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    lhs = base;
                    for (int k = 0; k < 5; k++) begin
                        lhs = lhs * 256'(mid);
                    end
                    if (lhs >= lim) begin
                        hi = mid;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
            tbl[c*GTW +: GTW] = GTW'(lo);
        end
        return tbl;
    endfunction

endpackage

>>> rtl/sage_div_step.sv
module sage_div_step #(
    parameter int FRACTION_BITS    = sage_pkg::FRACTION_BITS_DEF,
    parameter int GAMMA_TABLE_BITS = sage_pkg::GAMMA_TABLE_BITS_DEF,
    parameter int SHIFT            = 0
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  sage_pkg::ctl_t                                   ctl_in,
    input  logic [sage_pkg::CHANNELS-1:0][sage_pkg::ACCUM_W-1:0] rem_in,
    input  logic [sage_pkg::CHANNELS-1:0][sage_pkg::quotient_bits(FRACTION_BITS,
                                          GAMMA_TABLE_BITS)-1:0] quo_in,
    input  logic [sage_pkg::COUNT_W+sage_pkg::divisor_shift(FRACTION_BITS,
                                          GAMMA_TABLE_BITS)-1:0] dsr_in,
    output sage_pkg::ctl_t                                   ctl_out,
    output logic [sage_pkg::CHANNELS-1:0][sage_pkg::ACCUM_W-1:0] rem_out,
    output logic [sage_pkg::CHANNELS-1:0][sage_pkg::quotient_bits(FRACTION_BITS,
                                          GAMMA_TABLE_BITS)-1:0] quo_out,
    output logic [sage_pkg::COUNT_W+sage_pkg::divisor_shift(FRACTION_BITS,
                                          GAMMA_TABLE_BITS)-1:0] dsr_out
);

    localparam int QB = sage_pkg::quotient_bits(FRACTION_BITS, GAMMA_TABLE_BITS);
    localparam int DW = sage_pkg::COUNT_W + sage_pkg::divisor_shift(FRACTION_BITS,
                                                                     GAMMA_TABLE_BITS);
    localparam int CW = sage_pkg::compare_width(FRACTION_BITS);

    sage_pkg::ctl_t                                       ctl_reg;
    logic [sage_pkg::CHANNELS-1:0][sage_pkg::ACCUM_W-1:0] rem_reg;
    logic [sage_pkg::CHANNELS-1:0][sage_pkg::ACCUM_W-1:0] rem_next;
    logic [sage_pkg::CHANNELS-1:0][QB-1:0]                quo_reg;
    logic [sage_pkg::CHANNELS-1:0][QB-1:0]                quo_next;
    logic [DW-1:0]                                        dsr_reg;
    logic [CW:0]                                          sub_val;
    logic [CW:0]                                          trial [sage_pkg::CHANNELS];

    assign sub_val = {1'b0, CW'(dsr_in)} << SHIFT;

    // Restoring step: keep the difference when it does not borrow.
    always_comb
    begin
        for (int c = 0; c < sage_pkg::CHANNELS; c++) begin
            trial[c]    = {1'b0, CW'(rem_in[c])} - sub_val;
            rem_next[c] = trial[c][CW] ? rem_in[c] : trial[c][sage_pkg::ACCUM_W-1:0];
            quo_next[c] = {quo_in[c][QB-2:0], ~trial[c][CW]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_in;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign dsr_out = dsr_reg;

endmodule

>>> rtl/sage_gamma_step.sv
module sage_gamma_step #(
    parameter int GAMMA_TABLE_BITS = sage_pkg::GAMMA_TABLE_BITS_DEF,
    parameter int BIT              = 0,
    parameter logic [sage_pkg::GTW*sage_pkg::CODE_LEVELS-1:0] THRESH = '0
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  sage_pkg::ctl_t                                       ctl_in,
    input  logic [sage_pkg::CHANNELS-1:0][GAMMA_TABLE_BITS-1:0]  idx_in,
    input  logic [sage_pkg::CHANNELS-1:0][sage_pkg::CODE_W-1:0]  code_in,
    output sage_pkg::ctl_t                                       ctl_out,
    output logic [sage_pkg::CHANNELS-1:0][GAMMA_TABLE_BITS-1:0]  idx_out,
    output logic [sage_pkg::CHANNELS-1:0][sage_pkg::CODE_W-1:0]  code_out
);

    sage_pkg::ctl_t                                      ctl_reg;
    logic [sage_pkg::CHANNELS-1:0][GAMMA_TABLE_BITS-1:0] idx_reg;
    logic [sage_pkg::CHANNELS-1:0][sage_pkg::CODE_W-1:0] code_reg;
    logic [sage_pkg::CHANNELS-1:0][sage_pkg::CODE_W-1:0] code_next;
    logic [sage_pkg::CODE_W-1:0]                         cand [sage_pkg::CHANNELS];
    logic [sage_pkg::GTW-1:0]                            thr  [sage_pkg::CHANNELS];

    // One bit of a binary search for the highest code whose threshold is reached.
    always_comb
    begin
        for (int c = 0; c < sage_pkg::CHANNELS; c++) begin
            cand[c]      = code_in[c] | (sage_pkg::CODE_W'(1) << BIT);
            thr[c]       = THRESH[int'(cand[c])*sage_pkg::GTW +: sage_pkg::GTW];
            code_next[c] = (thr[c] <= sage_pkg::GTW'(idx_in[c])) ? cand[c] : code_in[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_in;
        code_reg <= code_next;
    end

    assign ctl_out  = ctl_reg;
    assign idx_out  = idx_reg;
    assign code_out = code_reg;

endmodule

>>> rtl/sample_average_gamma_encoder.sv
// Channel   Signals                              Direction  Accepted when
// request   start, busy, pixel                   in         start && !busy
// result    done, result                         out        every cycle done is high
// config    cfg_valid, cfg_ready, cfg_index/data in         cfg_valid && cfg_ready
//
// One request per cycle; each result passes the input register, the overflow
// register, one divider stage per quotient bit, one code-search step per output
// bit and the output register.
// Reset clears all valid bits, sample_count to 1 and marker_column to 0.
// busy is never raised, and the result side cannot stall, so nothing ever waits.
module sample_average_gamma_encoder #(
    parameter int FRACTION_BITS    = sage_pkg::FRACTION_BITS_DEF,
    parameter int GAMMA_TABLE_BITS = sage_pkg::GAMMA_TABLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sage_pkg::pixel_t                    pixel,
    output logic                                done,
    output sage_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sage_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sage_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CH = sage_pkg::CHANNELS;
    localparam int QB = sage_pkg::quotient_bits(FRACTION_BITS, GAMMA_TABLE_BITS);
    localparam int DS = sage_pkg::divisor_shift(FRACTION_BITS, GAMMA_TABLE_BITS);
    localparam int UP = (GAMMA_TABLE_BITS > FRACTION_BITS) ?
                        GAMMA_TABLE_BITS - FRACTION_BITS : 0;
    localparam int DW = sage_pkg::COUNT_W + DS;
    localparam int CW = sage_pkg::compare_width(FRACTION_BITS);
    localparam int NS = sage_pkg::CODE_W;
    localparam logic [sage_pkg::GTW*sage_pkg::CODE_LEVELS-1:0] THRESH =
        sage_pkg::gamma_thresholds(GAMMA_TABLE_BITS);

    // Configuration registers
    logic [sage_pkg::COUNT_W-1:0]  sample_count_reg;
    logic [sage_pkg::COLUMN_W-1:0] marker_column_reg;

    // Input stage
    sage_pkg::ctl_t                            ctl_a_reg;
    sage_pkg::ctl_t                            ctl_a_next;
    logic [CH-1:0][sage_pkg::ACCUM_W-1:0]      acc_a_reg;
    logic [sage_pkg::COUNT_W-1:0]              dsr_a_reg;
    logic [sage_pkg::COUNT_W-1:0]              dsr_a_next;

    // Overflow stage
    sage_pkg::ctl_t                            ctl_b_reg;
    sage_pkg::ctl_t                            ctl_b_next;
    logic [CH-1:0][sage_pkg::ACCUM_W-1:0]      rem_b_reg;
    logic [DW-1:0]                             dsr_b_reg;
    logic [CW-1:0]                             one_limit;

    // Divider and code-search chains
    sage_pkg::ctl_t                            ctl_d [QB+1];
    logic [CH-1:0][sage_pkg::ACCUM_W-1:0]      rem_d [QB+1];
    logic [CH-1:0][QB-1:0]                     quo_d [QB+1];
    logic [DW-1:0]                             dsr_d [QB+1];
    sage_pkg::ctl_t                            ctl_g  [NS+1];
    logic [CH-1:0][GAMMA_TABLE_BITS-1:0]       idx_g  [NS+1];
    logic [CH-1:0][sage_pkg::CODE_W-1:0]       code_g [NS+1];

    // Output stage
    logic                                      done_reg;
    sage_pkg::result_t                         result_reg;
    sage_pkg::result_t                         result_next;
    logic [CH-1:0][sage_pkg::CODE_W-1:0]       chan_code;

    logic                                      col_outside;
    logic                                      col_right;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sample_count_reg  <= sage_pkg::COUNT_W'(1);
            marker_column_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sage_pkg::REG_SAMPLE_COUNT:
                begin
                    sample_count_reg <= cfg_data[sage_pkg::COUNT_W-1:0];
                end
                sage_pkg::REG_MARKER_COLUMN:
                begin
                    marker_column_reg <= cfg_data[sage_pkg::COLUMN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pick the divisor and classify the pixel.
    always_comb
    begin
        col_outside      = int'(pixel.pixel_column) >= sage_pkg::MAX_COLUMNS;
        col_right        = pixel.pixel_column > marker_column_reg;
        dsr_a_next       = col_right ? sample_count_reg - sage_pkg::COUNT_W'(1)
                                     : sample_count_reg;
        ctl_a_next.valid = start && !busy;
        ctl_a_next.ovf   = '0;
        if (col_outside) begin
            ctl_a_next.kind = sage_pkg::KIND_BLANK;
        end else if (pixel.pixel_column == marker_column_reg) begin
            ctl_a_next.kind = sage_pkg::KIND_MARKER;
        end else if (sample_count_reg == '0 ||
                     (col_right && sample_count_reg == sage_pkg::COUNT_W'(1))) begin
            ctl_a_next.kind = sage_pkg::KIND_BLANK;
        end else begin
            ctl_a_next.kind = sage_pkg::KIND_NORMAL;
        end
    end

    // Mean at or above 1.0 saturates; below it the quotient fits in QB bits.
    assign one_limit = CW'(dsr_a_reg) << FRACTION_BITS;

    always_comb
    begin
        ctl_b_next = ctl_a_reg;
        for (int c = 0; c < CH; c++) begin
            ctl_b_next.ovf[c] = CW'(acc_a_reg[c]) >= one_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_b_next;
            done_reg  <= ctl_g[NS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_a_reg  <= {pixel.accum_red, pixel.accum_green, pixel.accum_blue};
        dsr_a_reg  <= dsr_a_next;
        rem_b_reg  <= acc_a_reg;
        dsr_b_reg  <= DW'(dsr_a_reg) << DS;
        result_reg <= result_next;
    end

    assign ctl_d[0] = ctl_b_reg;
    assign rem_d[0] = rem_b_reg;
    assign quo_d[0] = '0;
    assign dsr_d[0] = dsr_b_reg;

    for (genvar s = 0; s < QB; s++) begin : g_div
        sage_div_step #(
            .FRACTION_BITS   (FRACTION_BITS),
            .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS),
            .SHIFT           (QB - 1 - s)
        ) u_div_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl_in (ctl_d[s]),
            .rem_in (rem_d[s]),
            .quo_in (quo_d[s]),
            .dsr_in (dsr_d[s]),
            .ctl_out(ctl_d[s+1]),
            .rem_out(rem_d[s+1]),
            .quo_out(quo_d[s+1]),
            .dsr_out(dsr_d[s+1])
        );
    end

    assign ctl_g[0]  = ctl_d[QB];
    assign code_g[0] = '0;

    always_comb
    begin
        for (int c = 0; c < CH; c++) begin
            idx_g[0][c] = GAMMA_TABLE_BITS'(quo_d[QB][c]) << UP;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_gamma
        sage_gamma_step #(
            .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS),
            .BIT             (NS - 1 - s),
            .THRESH          (THRESH)
        ) u_gamma_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_g[s]),
            .idx_in  (idx_g[s]),
            .code_in (code_g[s]),
            .ctl_out (ctl_g[s+1]),
            .idx_out (idx_g[s+1]),
            .code_out(code_g[s+1])
        );
    end

    // Saturate, blank or draw the marker.
    always_comb
    begin
        for (int c = 0; c < CH; c++) begin
            chan_code[c] = ctl_g[NS].ovf[c] ? sage_pkg::CODE_W'(sage_pkg::CODE_MAX)
                                            : code_g[NS][c];
        end
        case (ctl_g[NS].kind)
            sage_pkg::KIND_NORMAL:
            begin
                result_next.red   = chan_code[2];
                result_next.green = chan_code[1];
                result_next.blue  = chan_code[0];
            end
            sage_pkg::KIND_MARKER:
            begin
                result_next.red   = '0;
                result_next.green = '0;
                result_next.blue  = sage_pkg::CODE_W'(sage_pkg::CODE_MAX);
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/sage_checker.sv
`include "sample_average_gamma_encoder_macros.svh"

module sage_checker #(
    parameter int FRACTION_BITS    = sage_pkg::FRACTION_BITS_DEF,
    parameter int GAMMA_TABLE_BITS = sage_pkg::GAMMA_TABLE_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_valid,
    input logic cfg_ready
);

    localparam int LAT = sage_pkg::pipe_latency(FRACTION_BITS, GAMMA_TABLE_BITS);

    // Every accepted request yields its result a fixed number of cycles later.
    `SAGE_ASSERT_NEXT(a_request_gets_result, start && !busy, ##(LAT-1) done)
    // No result without a request that many cycles earlier.
    `SAGE_ASSERT_SAME(a_result_has_request, done, $past(start && !busy, LAT))
    // Configuration writes are never held off.
    `SAGE_ASSERT_SAME(a_cfg_never_stalls, cfg_valid, cfg_ready)

endmodule

bind sample_average_gamma_encoder sage_checker #(
    .FRACTION_BITS   (FRACTION_BITS),
    .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)
) u_sage_checker (.*);
